@@ rtl/wmfp_pkg.sv @@
// ----------------------------------------------------------------------------
// wmfp_pkg
// shared types and constants of the monitor-mode frame parser
// ----------------------------------------------------------------------------
package wmfp_pkg;

   localparam int RT_MIN_BYTES = 38;
   localparam int POS_FREQ = 26;
   localparam int POS_SIG = 30;
   localparam int POS_FC = 38;
   localparam int HDR_MIN_BYTES = 62;

   localparam logic [2:0] ST_NONE = 3'd0;
   localparam logic [2:0] ST_NAMED = 3'd1;
   localparam logic [2:0] ST_BCAST = 3'd2;
   localparam logic [2:0] ST_HIDDEN = 3'd3;
   localparam logic [2:0] ST_CRYPT = 3'd4;
   localparam logic [2:0] ST_HSHAKE = 3'd5;

   localparam logic RK_SUMMARY = 1'b0;
   localparam logic RK_SSID = 1'b1;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [5:0]  ssid_len;
      logic [2:0]  ssid_status;
      logic [5:0]  frame_code;
      logic        header_valid;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [7:0]  rssi_dbm;
      logic [9:0]  channel;
      logic        is_monitor;
   } summary_type;

   // floor(x / 5) by reciprocal multiply, exact over the 16-bit range
   function automatic logic [15:0] div5(input logic [15:0] x);
      logic [31:0] p;
      begin
         p = 32'(x) * 32'd52429;
         return {2'b00, p[31:18]};
      end
   endfunction

   // frequency to channel, truncating division by 5
   function automatic logic [9:0] freq_to_channel(input logic [15:0] f);
      logic [15:0] d;
      logic [9:0]  q;
      begin
         d = '0;
         q = '0;
         if (f < 16'd2400 || f > 16'd6000) begin
            q = '0;
         end else if (f == 16'd2484) begin
            q = 10'd14;
         end else if (f < 16'd2484) begin
            if (f < 16'd2407) begin
               d = div5(16'd2407 - f);
               q = -d[9:0];
            end else begin
               d = div5(f - 16'd2407);
               q = d[9:0];
            end
         end else if (f < 16'd5000) begin
            d = div5(16'd5000 - f);
            q = -d[9:0];
         end else begin
            d = div5(f - 16'd5000);
            q = d[9:0];
         end
         return q;
      end
   endfunction

endpackage

@@ rtl/wmfp_ssid_mem.sv @@
// ----------------------------------------------------------------------------
// wmfp_ssid_mem
// ssid byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module wmfp_ssid_mem import wmfp_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/wifi_monitor_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// wifi_monitor_frame_parser_unit
// radiotap / 802.11 frame parser emitting a summary and the ssid bytes
// ----------------------------------------------------------------------------
// the request stream carries one frame byte per beat, tlast on the final
// byte. the response stream gives one summary beat per frame followed by
// ssid_len ssid beats, tlast on the final beat of the frame.
// bytes are taken one per cycle while the block is collecting a frame.
// after the last byte the block stops taking bytes and replays the frame:
// a summary beat, then one ssid beat per cycle while the response register
// is free, each ssid byte coming from the store through its registered read
// port. the request side stays closed until the last beat of the frame is
// loaded into the response register.
// the response register holds its beat while rsp_tready is low; the next
// record waits until the register is free.
// reset clears all parse state and empties the response register; the
// ssid store is not cleared, a byte is only read after it was written.
// ----------------------------------------------------------------------------
module wifi_monitor_frame_parser_unit import wmfp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 4096,
   parameter int SSID_MAX = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // is_monitor, channel, rssi_dbm, dst_mac,
                                     // src_mac, header_valid, frame_code,
                                     // ssid_status, ssid_len, ssid_byte, pad
   output logic         rsp_tuser,   // record_kind
   output logic         rsp_tlast    // last_of_run
);
   localparam int AW = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1;

   typedef enum logic [1:0] {S_COLLECT, S_SUMMARY, S_SSID} state_type;
   typedef enum logic [1:0] {PH_IDLE, PH_ID, PH_LEN} phase_type;

   state_type   state_ff;
   phase_type   phase_ff;
   logic [15:0] pos_ff;
   logic        fbz_ff;
   logic [15:0] rtlen_ff, freq_ff, ntag_ff, tagend_ff;
   logic [7:0]  sig_ff, fc_ff, tagid_ff, taglen_ff;
   logic [47:0] da_ff, sa_ff;
   logic        found_ff;
   logic [3:0]  llc_ff;
   summary_type sum_ff;
   logic [5:0]  k_ff;
   logic        rd_pend_ff;

   logic        ov_ff, ok_ff, last_ff;
   summary_type ov_sum_ff;
   logic [7:0]  ov_byte_ff;

   logic        take, wr_en, adv;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]  rd_data;
   logic [1:0]  ftype, ftype_c;
   logic [3:0]  fsub, fsub_c;
   logic [15:0] base, start, off, n;
   logic [7:0]  clen;
   logic        mon, hdr, walk;
   summary_type sum_in;

   assign req_tready = (state_ff == S_COLLECT);
   assign take = req_tvalid && req_tready;

   assign ftype = fc_ff[3:2];
   assign fsub = fc_ff[7:4];
   assign ftype_c = (pos_ff == 16'(POS_FC)) ? req_tdata[3:2] : ftype;
   assign fsub_c = (pos_ff == 16'(POS_FC)) ? req_tdata[7:4] : fsub;
   assign base = 16'(POS_FC) + ((fsub_c[3]) ? 16'd26 : 16'd24);
   assign clen = (taglen_ff < 8'(SSID_MAX)) ? taglen_ff : 8'(SSID_MAX);
   assign start = tagend_ff - 16'(taglen_ff);
   assign off = pos_ff - start;
   assign wr_en = take && (pos_ff < 16'(MAX_FRAME_BYTES)) && found_ff
                  && (pos_ff >= start) && (off < 16'(clen));
   assign wr_addr = off[AW-1:0];

   // read address follows the index the next ssid beat will use
   assign adv = rd_pend_ff && (!ov_ff || rsp_tready);
   assign rd_addr = (state_ff == S_SSID) ? (adv ? AW'(k_ff + 6'd1) : AW'(k_ff)) : '0;

   wmfp_ssid_mem #(.DEPTH(2 ** AW)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data(req_tdata), .rd_addr, .rd_data
   );

   // summary from the finished frame (pos_ff holds the frame size)
   always_comb begin
      n = pos_ff;
      mon = (n >= 16'(RT_MIN_BYTES)) && fbz_ff && (rtlen_ff != 16'd0)
            && (rtlen_ff < 16'd256) && (rtlen_ff <= n);
      hdr = mon && (n > 16'(HDR_MIN_BYTES));
      walk = (ftype == 2'd0) && (fsub == 4'd8 || fsub == 4'd5 || fsub == 4'd4);
      sum_in = '0;
      if (mon) begin
         sum_in.is_monitor = 1'b1;
         sum_in.channel = freq_to_channel(freq_ff);
         sum_in.rssi_dbm = sig_ff;
      end
      if (hdr) begin
         sum_in.header_valid = 1'b1;
         sum_in.dst_mac = da_ff;
         sum_in.src_mac = sa_ff;
         sum_in.frame_code = {ftype, fsub};
         if (walk && found_ff && tagend_ff <= n) begin
            sum_in.ssid_len = clen[5:0];
            sum_in.ssid_status = (clen != 8'd0) ? ST_NAMED
                                 : ((fsub == 4'd4) ? ST_BCAST : ST_HIDDEN);
         end else if (ftype == 2'd2) begin
            sum_in.ssid_status = (16'(POS_FC) + ((fsub[3]) ? 16'd34 : 16'd32) <= n
                                  && llc_ff == 4'hF) ? ST_HSHAKE : ST_CRYPT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         phase_ff <= PH_IDLE;
         pos_ff <= '0; fbz_ff <= 1'b0; rtlen_ff <= '0; freq_ff <= '0;
         sig_ff <= '0; fc_ff <= '0; da_ff <= '0; sa_ff <= '0;
         ntag_ff <= '0; tagid_ff <= '0; taglen_ff <= '0; tagend_ff <= '0;
         found_ff <= 1'b0; llc_ff <= '0; k_ff <= '0; rd_pend_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (ov_ff && rsp_tready) begin
            ov_ff <= 1'b0;
         end
         rd_pend_ff <= 1'b0;
         case (state_ff)
            S_COLLECT: begin
               if (take) begin
                  if (pos_ff < 16'(MAX_FRAME_BYTES)) begin
                     pos_ff <= pos_ff + 16'd1;
                     if (pos_ff == 16'd0) fbz_ff <= (req_tdata == 8'd0);
                     if (pos_ff == 16'd2) rtlen_ff[7:0] <= req_tdata;
                     if (pos_ff == 16'd3) rtlen_ff[15:8] <= req_tdata;
                     if (pos_ff == 16'(POS_FREQ)) freq_ff[7:0] <= req_tdata;
                     if (pos_ff == 16'(POS_FREQ + 1)) freq_ff[15:8] <= req_tdata;
                     if (pos_ff == 16'(POS_SIG)) sig_ff <= req_tdata;
                     if (pos_ff >= 16'd42 && pos_ff <= 16'd47)
                        da_ff <= {da_ff[39:0], req_tdata};
                     if (pos_ff >= 16'd48 && pos_ff <= 16'd53)
                        sa_ff <= {sa_ff[39:0], req_tdata};
                     if (pos_ff > 16'(POS_FC) && ftype_c == 2'd2) begin
                        if (pos_ff == base && req_tdata == 8'hAA) llc_ff[0] <= 1'b1;
                        if (pos_ff == base + 16'd1 && req_tdata == 8'hAA)
                           llc_ff[1] <= 1'b1;
                        if (pos_ff == base + 16'd6 && req_tdata == 8'h88)
                           llc_ff[2] <= 1'b1;
                        if (pos_ff == base + 16'd7 && req_tdata == 8'h8E)
                           llc_ff[3] <= 1'b1;
                     end
                     if (pos_ff == 16'(POS_FC)) begin
                        fc_ff <= req_tdata;
                        if (req_tdata[3:2] == 2'd0 && (req_tdata[7:4] == 4'd8
                            || req_tdata[7:4] == 4'd5 || req_tdata[7:4] == 4'd4)) begin
                           ntag_ff <= (req_tdata[7:4] == 4'd4) ? 16'd62 : 16'd74;
                           phase_ff <= PH_ID;
                        end
                     end else if (phase_ff == PH_ID && pos_ff == ntag_ff) begin
                        tagid_ff <= req_tdata;
                        phase_ff <= PH_LEN;
                     end else if (phase_ff == PH_LEN) begin
                        taglen_ff <= req_tdata;
                        if (tagid_ff == 8'd0) begin
                           found_ff <= 1'b1;
                           tagend_ff <= pos_ff + 16'd1 + 16'(req_tdata);
                           phase_ff <= PH_IDLE;
                        end else begin
                           ntag_ff <= pos_ff + 16'd1 + 16'(req_tdata);
                           phase_ff <= PH_ID;
                        end
                     end
                  end
                  if (req_tlast) state_ff <= S_SUMMARY;
               end
            end
            S_SUMMARY: begin
               if (!ov_ff || rsp_tready) begin
                  ov_ff <= 1'b1;
                  ok_ff <= RK_SUMMARY;
                  ov_sum_ff <= sum_in;
                  ov_byte_ff <= '0;
                  last_ff <= (sum_in.ssid_len == 6'd0);
                  sum_ff <= sum_in;
                  k_ff <= '0;
                  pos_ff <= '0; fbz_ff <= 1'b0; rtlen_ff <= '0; freq_ff <= '0;
                  sig_ff <= '0; fc_ff <= '0; da_ff <= '0; sa_ff <= '0;
                  ntag_ff <= '0; tagid_ff <= '0; taglen_ff <= '0;
                  tagend_ff <= '0; found_ff <= 1'b0; llc_ff <= '0;
                  phase_ff <= PH_IDLE;
                  if (sum_in.ssid_len == 6'd0) begin
                     state_ff <= S_COLLECT;
                  end else begin
                     state_ff <= S_SSID;
                     rd_pend_ff <= 1'b1;
                  end
               end
            end
            S_SSID: begin
               // rd_data holds the entry for k_ff
               if (rd_pend_ff) begin
                  if (!ov_ff || rsp_tready) begin
                     ov_ff <= 1'b1;
                     ok_ff <= RK_SSID;
                     ov_sum_ff <= sum_ff;
                     ov_byte_ff <= rd_data;
                     last_ff <= (k_ff + 6'd1 == sum_ff.ssid_len);
                     k_ff <= k_ff + 6'd1;
                     if (k_ff + 6'd1 == sum_ff.ssid_len) begin
                        state_ff <= S_COLLECT;
                     end else begin
                        rd_pend_ff <= 1'b1;
                     end
                  end else begin
                     rd_pend_ff <= 1'b1;
                  end
               end else begin
                  rd_pend_ff <= 1'b1;
               end
            end
            default: state_ff <= S_COLLECT;
         endcase
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser = ok_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {5'b0, ov_byte_ff, ov_sum_ff};
endmodule

@@ rtl/wmfp_checker.sv @@
// ----------------------------------------------------------------------------
// wmfp_port_checker
// port-level checks of the frame parser, bound to the top level
// ----------------------------------------------------------------------------
module wmfp_port_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_summary_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[138:131] == 8'd0)
      else $error("summary beat carries an ssid byte");

   a_ssid_after: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("new frame taken inside a record run");

   a_last_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[130:125] == 6'd0 |-> rsp_tlast)
      else $error("summary without ssid not marked last");
endmodule

bind wifi_monitor_frame_parser_unit wmfp_port_checker u_wmfp_port_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser, .rsp_tlast
);

@@ dv/wmfp_checker.sv @@
// ----------------------------------------------------------------------------
// wmfp_checker
// watches the byte stream and the record stream of the frame parser, predicts
// the summary and ssid records of every frame and compares them in order
// ----------------------------------------------------------------------------
module wmfp_checker import wmfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   output int           errors,
   output int           pending,
   output int           records_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_MAX = 4096;
   localparam int NAME_MAX = 32;
   localparam logic [1:0] WALK_IDLE = 2'd0;
   localparam logic [1:0] WALK_ID = 2'd1;
   localparam logic [1:0] WALK_LEN = 2'd2;

   typedef struct packed {
      logic        kind;
      logic        mon;
      logic [9:0]  chan;
      logic [7:0]  sig;
      logic [47:0] da;
      logic [47:0] sa;
      logic        hv;
      logic [5:0]  code;
      logic [2:0]  st;
      logic [5:0]  len;
      logic [7:0]  sb;
      logic        lst;
   } record_type;

   record_type record_q[$];

   int          pos, rt_len, freq, sig_raw, fc, tag_pos, tag_id, tag_len, ssid_end;
   int          llc_hits;
   logic        rt_zero, ssid_seen;
   logic [1:0]  walk;
   logic [47:0] da, sa;
   logic [7:0]  ssid_mem [NAME_MAX];

   assign pending = record_q.size();

   task automatic clear_frame();
      pos = 0; rt_zero = 0; rt_len = 0; freq = 0; sig_raw = 0; fc = 0;
      da = '0; sa = '0; tag_pos = 0; walk = WALK_IDLE; tag_id = 0; tag_len = 0;
      ssid_end = 0; ssid_seen = 0; llc_hits = 0;
   endtask

   function automatic int chan_of(input int f);
      if (f < 2400 || f > 6000) return 0;
      if (f == 2484) return 14;
      if (f < 2484) return (f - 2407) / 5;
      return (f - 5000) / 5;
   endfunction

   function automatic int name_len();
      return (tag_len < NAME_MAX) ? tag_len : NAME_MAX;
   endfunction

   task automatic parse_byte(input int p, input int b);
      int ft, fs, hbase, start;
      ft = (fc >> 2) & 3;
      fs = (fc >> 4) & 15;
      if (p == 0) rt_zero = (b == 0);
      if (p == 2) rt_len = (rt_len & 'hFF00) | b;
      if (p == 3) rt_len = (rt_len & 'h00FF) | (b << 8);
      if (p == POS_FREQ) freq = (freq & 'hFF00) | b;
      if (p == POS_FREQ + 1) freq = (freq & 'h00FF) | (b << 8);
      if (p == POS_SIG) sig_raw = b;
      if (p == POS_FC) begin
         fc = b;
         ft = (b >> 2) & 3;
         fs = (b >> 4) & 15;
         if (ft == 0 && (fs == 8 || fs == 5 || fs == 4)) begin
            tag_pos = (fs == 4) ? 62 : 74;
            walk = WALK_ID;
         end
      end
      if (p >= 42 && p <= 47) da = {da[39:0], 8'(b)};
      if (p >= 48 && p <= 53) sa = {sa[39:0], 8'(b)};
      if (p > POS_FC && ft == 2) begin
         hbase = POS_FC + ((fs & 8) ? 26 : 24);
         if (p == hbase && b == 'hAA) llc_hits |= 1;
         if (p == hbase + 1 && b == 'hAA) llc_hits |= 2;
         if (p == hbase + 6 && b == 'h88) llc_hits |= 4;
         if (p == hbase + 7 && b == 'h8E) llc_hits |= 8;
      end
      if (ssid_seen) begin
         start = ssid_end - tag_len;
         if (p >= start && p - start < name_len()) ssid_mem[(p - start) % NAME_MAX] = 8'(b);
      end
      if (walk == WALK_ID && p == tag_pos) begin
         tag_id = b;
         walk = WALK_LEN;
      end else if (walk == WALK_LEN) begin
         tag_len = b;
         if (tag_id == 0) begin
            ssid_seen = 1;
            ssid_end = p + 1 + b;
            walk = WALK_IDLE;
         end else begin
            tag_pos = p + 1 + b;
            walk = WALK_ID;
         end
      end
   endtask

   task automatic predict_frame(input logic [7:0] b, input logic last);
      int n, ft, fs, slen;
      logic mon, hdr;
      record_type r;
      if (pos < FRAME_MAX) begin
         parse_byte(pos, b);
         pos++;
      end
      if (!last) return;
      n = pos;
      slen = 0;
      mon = n >= RT_MIN_BYTES && rt_zero && rt_len > 0 && rt_len < 256 && rt_len <= n;
      hdr = mon && n > HDR_MIN_BYTES;
      ft = (fc >> 2) & 3;
      fs = (fc >> 4) & 15;
      r = '0;
      r.mon = mon;
      r.hv = hdr;
      if (mon) begin
         r.chan = 10'(chan_of(freq));
         r.sig = 8'(sig_raw);
      end
      if (hdr) begin
         r.da = da;
         r.sa = sa;
         r.code = 6'(ft * 16 + fs);
         if (ft == 0 && (fs == 8 || fs == 5 || fs == 4) && ssid_seen && ssid_end <= n) begin
            slen = name_len();
            r.st = (slen > 0) ? ST_NAMED : ((fs == 4) ? ST_BCAST : ST_HIDDEN);
         end else if (ft == 2) begin
            r.st = (POS_FC + ((fs & 8) ? 26 : 24) + 8 <= n && llc_hits == 15) ?
                   ST_HSHAKE : ST_CRYPT;
         end
      end
      r.len = 6'(slen);
      for (int k = 0; k <= slen; k++) begin
         r.kind = (k == 0) ? RK_SUMMARY : RK_SSID;
         r.sb = (k == 0) ? 8'd0 : ssid_mem[(k - 1) % NAME_MAX];
         r.lst = (k == slen);
         record_q.push_back(r);
      end
      clear_frame();
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   task automatic check_record();
      record_type e;
      logic [143:0] d;
      d = rsp_tdata;
      records_seen++;
      if (record_q.size() == 0) begin
         errors++;
         $display("%0t unexpected record beat, actual %0h", $time, rsp_tdata);
         return;
      end
      e = record_q.pop_front();
      check_field("record_kind", e.kind, rsp_tuser);
      check_field("is_monitor", e.mon, d[0]);
      check_field("channel", e.chan, d[10:1]);
      check_field("rssi_dbm", e.sig, d[18:11]);
      check_field("dst_mac", e.da, d[66:19]);
      check_field("src_mac", e.sa, d[114:67]);
      check_field("header_valid", e.hv, d[115]);
      check_field("frame_code", e.code, d[121:116]);
      check_field("ssid_status", e.st, d[124:122]);
      check_field("ssid_len", e.len, d[130:125]);
      check_field("ssid_byte", e.sb, d[138:131]);
      check_field("last_of_run", e.lst, rsp_tlast);
   endtask

   initial begin
      errors = 0;
      records_seen = 0;
      clear_frame();
      foreach (ssid_mem[i]) ssid_mem[i] = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_frame(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_record();
      end
   end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives generated frames byte by byte into the frame parser with random gaps
// and back-pressure, and leaves the record checking to wmfp_checker
// ----------------------------------------------------------------------------
module tb_top import wmfp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 3000;
   localparam int HOLD_CYCLES = 400;

   localparam int K_BEACON = 0;
   localparam int K_PRESP = 1;
   localparam int K_PREQ = 2;
   localparam int K_DATA = 3;
   localparam int K_QOS = 4;
   localparam int K_CTRL = 5;
   localparam int K_NOISE = 6;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tlast;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tuser, rsp_tlast;
   logic [143:0] rsp_tdata;
   int           errors, pending, records_seen, frames_sent, beats_taken, idle_cycles;

   wifi_monitor_frame_parser_unit u_top (.*);

   wmfp_checker u_checker (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(input int kind, input int freq, input int rtlen,
                             input logic [7:0] b0, input int slen, input int trunc,
                             input logic llc_ok);
      logic [7:0] q[$];
      int start, hl;
      q = {};
      if (kind == K_NOISE) begin
         repeat (slen) q.push_back(8'($urandom));
      end else begin
         repeat (38) q.push_back(8'($urandom));
         q[0] = b0;
         q[2] = rtlen[7:0];
         q[3] = rtlen[15:8];
         q[26] = freq[7:0];
         q[27] = freq[15:8];
         case (kind)
            K_BEACON: q.push_back(8'h80);
            K_PRESP: q.push_back(8'h50);
            K_PREQ: q.push_back(8'h40);
            K_DATA: q.push_back(8'h08);
            K_QOS: q.push_back(8'h88);
            default: q.push_back(8'($urandom_range(0, 1) ? 8'hB4 : 8'($urandom)));
         endcase
         repeat (15) q.push_back(8'($urandom));
         if (kind <= K_PREQ) begin
            start = (kind == K_PREQ) ? 62 : 74;
            while (q.size() < start) q.push_back(8'($urandom));
            repeat ($urandom_range(0, 2)) begin
               q.push_back(8'($urandom_range(1, 255)));
               hl = $urandom_range(0, 6);
               q.push_back(8'(hl));
               repeat (hl) q.push_back(8'($urandom));
            end
            q.push_back(8'h00);
            q.push_back(8'(slen));
            repeat (slen) q.push_back(8'($urandom));
            repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
         end else if (kind <= K_QOS) begin
            hl = (kind == K_QOS) ? 26 : 24;
            while (q.size() < 38 + hl) q.push_back(8'($urandom));
            start = q.size();
            q.push_back(8'hAA); q.push_back(8'hAA); q.push_back(8'h03);
            q.push_back(8'h00); q.push_back(8'h00); q.push_back(8'h00);
            q.push_back(8'h88); q.push_back(8'h8E);
            if (!llc_ok) q[start + 2 * $urandom_range(0, 3) - ($urandom_range(0, 1))] ^= 8'h10;
            repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(0, 30)) q.push_back(8'($urandom));
         end
      end
      repeat (trunc) if (q.size() > 1) void'(q.pop_back());
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
      frames_sent++;
   endtask

   // receiver: random stalls per beat, one long hold-off early on
   initial begin
      int gap;
      rsp_tready = 1'b0;
      beats_taken = 0;
      @(negedge reset);
      forever begin
         if (beats_taken == 3) gap = HOLD_CYCLES;
         else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         beats_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      frames_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_frame(K_NOISE, 0, 0, 0, 1, 0, 1);
      send_frame(K_NOISE, 0, 0, 0, 37, 0, 1);
      send_frame(K_CTRL, 2412, 8, 8'h00, 0, 100, 1);
      send_frame(K_BEACON, 2484, 18, 8'h00, 34, 0, 1);
      send_frame(K_PREQ, 2407, 12, 8'h00, 0, 0, 1);
      wait (pending == 0);

      send_frame(K_QOS, 2437, 20, 8'h00, 0, 0, 1);
      send_frame(K_DATA, 5180, 20, 8'h00, 0, 30, 0);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      wait (pending == 0);
      repeat (50) @(posedge clock);
      $display("frames sent %0d, record beats checked %0d", frames_sent, records_seen);
      $display("covered short and foreign frames, a clipped ssid, a probe request, eapol");
      $display("and a data frame cut short, under random gaps and a long receiver hold");
      if (errors == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/wmfp_pkg.sv
rtl/wmfp_ssid_mem.sv
rtl/wifi_monitor_frame_parser_unit.sv
rtl/wmfp_checker.sv
dv/wmfp_checker.sv
dv/tb_top.sv
